[rtl/mfhs_pkg.sv]
// Package with the shared types and constants of the motor fader hold-off scheduler.
package mfhs_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned DRV_IDX_W  = 4;
  localparam int unsigned DRV_POS_W  = 12;

  localparam logic [HOLD_W-1:0] HOLD_RESET      = 8'd10;
  localparam logic [7:0]        MAX_DRIVE_INDEX = 8'd12;

  typedef enum logic [1:0] {
    OP_SET_TARGET = 2'd0,
    OP_TOUCH      = 2'd1,
    OP_TICK       = 2'd2,
    OP_RESET_ALL  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [POS_W-1:0]  target;
    logic [POS_W-1:0]  current;
    logic [HOLD_W-1:0] holdoff;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic upd;
    logic flush;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    last_fader;
    logic    stall;
    logic    pend_valid;
    logic    out_free;
  } status_t;

endpackage

[rtl/mfhs_if.sv]
// Handshake channel interfaces for input items and drive commands.
interface mfhs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  fader_index;
  logic [15:0] position;

  modport source (output valid, output opcode, output fader_index, output position,
                  input ready);
  modport sink (input valid, input opcode, input fader_index, input position,
                output ready);
endinterface

interface mfhs_drive_if;
  logic        valid;
  logic        ready;
  logic [3:0]  drive_index;
  logic [11:0] drive_position;
  logic        last;

  modport source (output valid, output drive_index, output drive_position, output last,
                  input ready);
  modport sink (input valid, input drive_index, input drive_position, input last,
                output ready);
endinterface

[rtl/mfhs_ctrl.sv]
// Controller state machine that sequences capture, single-fader update or fader sweep, and final flush.
module mfhs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mfhs_pkg::status_t status,
  output mfhs_pkg::cmd_t    cmd
);
  import mfhs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_UPD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.rd      = 1'b0;
    cmd.upd     = 1'b0;
    cmd.flush   = 1'b0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!status.stall) begin
          cmd.upd = 1'b1;
          if (status.op inside {OP_SET_TARGET, OP_TOUCH}) begin
            state_next = S_IDLE;
          end else if (status.last_fader) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/mfhs_dpath.sv]
// Datapath with the fader state memory, sweep counter, pending command and output register.
module mfhs_dpath #(
  parameter int unsigned NUM_FADERS = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [7:0]               cfg_wdata,
  input  logic [1:0]               in_opcode,
  input  logic [7:0]               in_fader_index,
  input  logic [15:0]              in_position,
  input  mfhs_pkg::cmd_t           cmd,
  output mfhs_pkg::status_t        status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_drive_index,
  output logic [11:0]              out_drive_position,
  output logic                     out_last
);
  import mfhs_pkg::*;

  localparam int unsigned ADDR_W = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;

  entry_t                 mem [NUM_FADERS];
  logic [NUM_FADERS-1:0]  valid;
  entry_t                 rd_data;
  logic                   rd_valid;

  logic [HOLD_W-1:0]      hold_ticks;
  opcode_t                op;
  logic [ADDR_W-1:0]      idx;
  logic [POS_W-1:0]       pos;
  logic                   in_range;

  logic                   pend_valid;
  logic [DRV_IDX_W-1:0]   pend_idx;
  logic [DRV_POS_W-1:0]   pend_pos;

  entry_t                 cur;
  entry_t                 new_entry;
  logic                   we;
  logic                   emit;
  logic [POS_W-1:0]       emit_pos;
  logic                   emit_ok;
  logic [7:0]             idx_ext;
  logic                   out_free;
  logic                   push_pend;
  logic                   upd_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op       <= opcode_t'(in_opcode);
      pos      <= in_position;
      in_range <= ({1'b0, in_fader_index} < 9'(NUM_FADERS));
      if (in_opcode == OP_TICK || in_opcode == OP_RESET_ALL) begin
        idx <= '0;
      end else begin
        idx <= in_fader_index[ADDR_W-1:0];
      end
    end else if (upd_go && (op == OP_TICK || op == OP_RESET_ALL)) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
    if (upd_go && we) begin
      mem[idx] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_valid <= valid[idx];
      end
      if (upd_go && we) begin
        valid[idx] <= 1'b1;
      end
    end
  end

  assign cur     = rd_valid ? rd_data : '0;
  assign idx_ext = 8'(idx);

  always_comb begin
    new_entry = cur;
    we        = 1'b0;
    emit      = 1'b0;
    emit_pos  = '0;
    case (op)
      OP_SET_TARGET: begin
        new_entry.target = pos;
        we               = in_range;
      end
      OP_TOUCH: begin
        new_entry.target  = pos;
        new_entry.current = pos;
        new_entry.holdoff = hold_ticks;
        we                = in_range;
      end
      OP_TICK: begin
        if (cur.holdoff != '0) begin
          new_entry.holdoff = cur.holdoff - 1'b1;
          we                = 1'b1;
        end else if (cur.current != cur.target) begin
          new_entry.current = cur.target;
          we                = 1'b1;
          emit              = 1'b1;
          emit_pos          = cur.target;
        end
      end
      OP_RESET_ALL: begin
        new_entry.current = '0;
        new_entry.holdoff = '0;
        we                = 1'b1;
        emit              = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign emit_ok   = emit && (idx_ext <= MAX_DRIVE_INDEX) && (emit_pos[POS_W-1:DRV_POS_W] == '0);
  assign out_free  = !out_valid || out_ready;
  assign upd_go    = cmd.upd;
  assign push_pend = (upd_go && emit_ok && pend_valid) || cmd.flush;

  assign status.op         = op;
  assign status.last_fader = (idx == ADDR_W'(NUM_FADERS - 1));
  assign status.stall      = emit_ok && pend_valid && !out_free;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (upd_go && emit_ok) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && emit_ok) begin
      pend_idx <= idx_ext[DRV_IDX_W-1:0];
      pend_pos <= emit_pos[DRV_POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_drive_index    <= pend_idx;
      out_drive_position <= pend_pos;
      out_last           <= cmd.flush;
    end
  end

endmodule

[rtl/motor_fader_holdoff_scheduler_core.sv]
// Top level of the motor fader hold-off scheduler.
// Each input transaction is taken only while the block is idle. A set-target or touch
// report is captured, read and updated; a tick or reset-all sweeps the faders one at a
// time, with a read and then an update per fader through the single-port state memory,
// and the sweep is held up while the drive channel stalls. Each drive command is
// held back one step so that the final one of a sweep can carry last; the output register
// lets the next input transaction be accepted while the final command still waits.
module motor_fader_holdoff_scheduler_core #(
  parameter int unsigned NUM_FADERS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  mfhs_item_if.sink   item,
  mfhs_drive_if.source drive
);
  import mfhs_pkg::*;

  cmd_t    cmd;
  status_t status;

  mfhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mfhs_dpath #(
    .NUM_FADERS (NUM_FADERS)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (item.opcode),
    .in_fader_index     (item.fader_index),
    .in_position        (item.position),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (drive.valid),
    .out_ready          (drive.ready),
    .out_drive_index    (drive.drive_index),
    .out_drive_position (drive.drive_position),
    .out_last           (drive.last)
  );

endmodule

[rtl/mfhs_checker.sv]
// Port-level checker for the motor fader hold-off scheduler and its bind statement.
module mfhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  drive_index,
  input logic [11:0] drive_position,
  input logic        last
);
  import mfhs_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_index)
      && $stable(drive_position) && $stable(last))
    else $error("Drive transaction changed while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 8'(drive_index) <= MAX_DRIVE_INDEX)
    else $error("Drive command for a fader beyond the last one.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted in consecutive cycles.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_SET_TARGET || opcode == OP_TOUCH)
      |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("Set-target or touch report produced a drive command.");

  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Block not idle after reset.");

endmodule

bind motor_fader_holdoff_scheduler_core mfhs_checker u_mfhs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .opcode         (item.opcode),
  .out_valid      (drive.valid),
  .out_ready      (drive.ready),
  .drive_index    (drive.drive_index),
  .drive_position (drive.drive_position),
  .last           (drive.last)
);

[test/motor_fader_holdoff_scheduler_core_checker.sv]
// Checker that predicts and compares the drive commands of the motor fader hold-off scheduler.
`timescale 1ns / 1ps

module motor_fader_holdoff_scheduler_core_checker #(
  parameter int unsigned NUM_FADERS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  mfhs_item_if        item,
  mfhs_drive_if       drive,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned cmd_count
);
  import mfhs_pkg::*;

  localparam int unsigned DRIVE_POS_MAX = 4095;

  typedef struct packed {
    logic [DRV_IDX_W-1:0] drive_index;
    logic [DRV_POS_W-1:0] drive_position;
    logic                 last;
  } drive_cmd_t;

  logic [POS_W-1:0]  target_pos  [NUM_FADERS];
  logic [POS_W-1:0]  current_pos [NUM_FADERS];
  logic [HOLD_W-1:0] holdoff_left[NUM_FADERS];
  logic [HOLD_W-1:0] hold_setting;
  drive_cmd_t        expected_drives[$];
  int unsigned       mismatches;
  int unsigned       drives_seen;

  initial begin
    fail_count = 0;
    pending = 0;
    cmd_count = 0;
    mismatches = 0;
    drives_seen = 0;
  end

  function automatic void predict_drive_commands(opcode_t op, logic [7:0] idx,
                                                 logic [POS_W-1:0] pos);
    drive_cmd_t cmds[$];
    drive_cmd_t cmd;
    case (op)
      OP_SET_TARGET: begin
        if (idx < NUM_FADERS) target_pos[idx] = pos;
      end
      OP_TOUCH: begin
        if (idx < NUM_FADERS) begin
          target_pos[idx] = pos;
          current_pos[idx] = pos;
          holdoff_left[idx] = hold_setting;
        end
      end
      OP_TICK: begin
        for (int f = 0; f < NUM_FADERS; f++) begin
          if (holdoff_left[f] != 0) begin
            holdoff_left[f] = holdoff_left[f] - 1'b1;
          end else if (current_pos[f] != target_pos[f]) begin
            current_pos[f] = target_pos[f];
            if (f <= MAX_DRIVE_INDEX && target_pos[f] <= DRIVE_POS_MAX) begin
              cmd.drive_index = DRV_IDX_W'(f);
              cmd.drive_position = target_pos[f][DRV_POS_W-1:0];
              cmd.last = 1'b0;
              cmds.push_back(cmd);
            end
          end
        end
      end
      default: begin
        for (int f = 0; f < NUM_FADERS; f++) begin
          holdoff_left[f] = '0;
          current_pos[f] = '0;
          if (f <= MAX_DRIVE_INDEX) begin
            cmd.drive_index = DRV_IDX_W'(f);
            cmd.drive_position = '0;
            cmd.last = 1'b0;
            cmds.push_back(cmd);
          end
        end
      end
    endcase
    if (cmds.size() > 0) cmds[cmds.size()-1].last = 1'b1;
    foreach (cmds[k]) expected_drives.push_back(cmds[k]);
  endfunction

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst) begin
      for (int f = 0; f < NUM_FADERS; f++) begin
        target_pos[f] = '0;
        current_pos[f] = '0;
        holdoff_left[f] = '0;
      end
      hold_setting = HOLD_RESET;
      expected_drives.delete();
    end else begin
      if (drive.valid && drive.ready) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected drive command, expected none,", $time,
                   " got fader %0d position %0d last %0b",
                   drive.drive_index, drive.drive_position, drive.last);
        end else begin
          want = expected_drives.pop_front();
          if (drive.drive_index !== want.drive_index ||
              drive.drive_position !== want.drive_position ||
              drive.last !== want.last) begin
            mismatches++;
            $display("%0t: drive command mismatch, expected fader %0d position %0d last %0b,",
                     $time, want.drive_index, want.drive_position, want.last,
                     " got fader %0d position %0d last %0b",
                     drive.drive_index, drive.drive_position, drive.last);
          end
        end
      end
      if (cfg_we) hold_setting = cfg_wdata;
      if (item.valid && item.ready)
        predict_drive_commands(opcode_t'(item.opcode), item.fader_index, item.position);
    end
    fail_count <= mismatches;
    pending <= expected_drives.size();
    cmd_count <= drives_seen;
  end

endmodule

[test/motor_fader_holdoff_scheduler_core_test.sv]
// Testbench top that drives the motor fader hold-off scheduler and gives the verdict.
`timescale 1ns / 1ps

module motor_fader_holdoff_scheduler_core_test;
  import mfhs_pkg::*;

  localparam int unsigned NUM_FADERS    = 13;
  localparam int unsigned SWEEP_CYCLES  = 2 * NUM_FADERS + 16;
  localparam int unsigned ITEMS_PER_SET = 44;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cmd_count;
  int unsigned cycle_count = 0;
  int unsigned item_total = 0;
  int unsigned tick_total = 0;
  int unsigned reset_total = 0;
  int unsigned cfg_writes = 0;
  bit          no_gaps = 1'b0;
  bit          long_holdoff = 1'b0;

  mfhs_item_if  item_ch ();
  mfhs_drive_if drive_ch ();

  motor_fader_holdoff_scheduler_core #(
    .NUM_FADERS(NUM_FADERS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch.sink),
    .drive    (drive_ch.source)
  );

  motor_fader_holdoff_scheduler_core_checker #(
    .NUM_FADERS(NUM_FADERS)
  ) checker_inst (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .drive     (drive_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .cmd_count (cmd_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("motor_fader_holdoff_scheduler_core test failed");
      $finish;
    end
  end

  task automatic offer_item(opcode_t op, logic [7:0] idx, logic [15:0] pos);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.fader_index <= idx;
    item_ch.position <= pos;
    do @(posedge clk); while (!item_ch.ready);
    item_total++;
    if (op == OP_TICK) tick_total++;
    if (op == OP_RESET_ALL) reset_total++;
  endtask

  task automatic random_item();
    int unsigned r;
    opcode_t     op;
    logic [7:0]  idx;
    logic [15:0] pos;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_SET_TARGET;
    else if (r < 50) op = OP_TOUCH;
    else if (r < 92) op = OP_TICK;
    else op = OP_RESET_ALL;
    if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(0, 255));
    else idx = 8'($urandom_range(0, NUM_FADERS - 1));
    r = $urandom_range(0, 9);
    if (r == 0) pos = 16'($urandom);
    else if (r == 1) pos = 16'($urandom_range(4096, 65535));
    else pos = 16'($urandom_range(0, 4095));
    offer_item(op, idx, pos);
  endtask

  // The last transaction may be a set target or touch report, which gives no result,
  // so the block is given time for a full sweep after the final expected command.
  task automatic quiesce();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold_ticks(logic [7:0] value);
    quiesce();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : drive_receiver
    int unsigned stall;
    drive_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_holdoff) begin
        long_holdoff = 1'b0;
        stall = LONG_HOLD;
      end else if (no_gaps) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        drive_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      drive_ch.ready <= 1'b1;
      do @(posedge clk); while (!drive_ch.valid);
    end
  end

  initial begin : stimulus
    logic [7:0] hold_values[6];
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= OP_SET_TARGET;
    item_ch.fader_index <= '0;
    item_ch.position <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_item(OP_TICK, 8'd0, 16'h0000);
    offer_item(OP_RESET_ALL, 8'd0, 16'h0000);
    offer_item(OP_SET_TARGET, 8'd0, 16'h0FFF);
    offer_item(OP_SET_TARGET, 8'd12, 16'hFFFF);
    offer_item(OP_SET_TARGET, 8'd13, 16'd123);
    offer_item(OP_SET_TARGET, 8'd255, 16'd5);
    offer_item(OP_SET_TARGET, 8'd5, 16'd4096);
    offer_item(OP_SET_TARGET, 8'd1, 16'h0AAA);
    offer_item(OP_SET_TARGET, 8'd2, 16'h0555);
    offer_item(OP_TICK, 8'd0, 16'h0000);
    offer_item(OP_TOUCH, 8'd3, 16'd100);
    offer_item(OP_SET_TARGET, 8'd3, 16'd200);
    offer_item(OP_TICK, 8'hFF, 16'hFFFF);
    offer_item(OP_TOUCH, 8'd13, 16'd77);
    offer_item(OP_TOUCH, 8'd255, 16'hFFFF);
    offer_item(OP_RESET_ALL, 8'hFF, 16'hFFFF);
    offer_item(OP_TICK, 8'd0, 16'h0000);
    offer_item(OP_SET_TARGET, 8'd7, 16'd1);
    offer_item(OP_TICK, 8'd0, 16'h0000);

    hold_values[0] = 8'd0;
    hold_values[1] = 8'd255;
    hold_values[2] = 8'd1;
    hold_values[3] = 8'd3;
    hold_values[4] = 8'($urandom_range(2, 254));
    hold_values[5] = HOLD_RESET;

    for (int s = 0; s < 6; s++) begin
      write_hold_ticks(hold_values[s]);
      if (s == 3) begin
        for (int f = 0; f < NUM_FADERS; f++)
          offer_item(OP_SET_TARGET, 8'(f), 16'($urandom_range(0, 4095)));
        long_holdoff = 1'b1;
        for (int k = 0; k < 6; k++) begin
          offer_item(OP_TICK, 8'd0, 16'h0000);
          offer_item(OP_SET_TARGET, 8'($urandom_range(0, NUM_FADERS - 1)),
                     16'($urandom_range(0, 4095)));
        end
      end
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        no_gaps = (s == 2 && k < 24);
        random_item();
      end
      no_gaps = 1'b0;
    end

    quiesce();
    $display("Run covered %0d input transactions (%0d ticks, %0d reset-all)",
             item_total, tick_total, reset_total);
    $display("and %0d drive commands across %0d hold-off settings, including 0 and 255.",
             cmd_count, cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("motor_fader_holdoff_scheduler_core test passed");
    end else begin
      $display("motor_fader_holdoff_scheduler_core test failed");
    end
    $finish;
  end

endmodule
